// ===== hw/rtl/juap_pkg.sv =====
// ----------------------------------------------------------------------------
// juap_pkg
// shared types and constants of the json unsigned integer array parser
// ----------------------------------------------------------------------------
package juap_pkg;

	// parse phase
	typedef enum logic [3:0] {
		PH_OPEN   = 4'd0,
		PH_FIRST  = 4'd1,
		PH_ELEM   = 4'd2,
		PH_NUM    = 4'd3,
		PH_AFTER  = 4'd4,
		PH_CLOSED = 4'd5,
		PH_EMPTY  = 4'd6
	} phase_t;

	// final status codes
	localparam logic [3:0] ST_OK          = 4'd0;
	localparam logic [3:0] ST_NOT_ARRAY   = 4'd1;
	localparam logic [3:0] ST_EMPTY       = 4'd2;
	localparam logic [3:0] ST_TRAILING    = 4'd3;
	localparam logic [3:0] ST_NON_INT     = 4'd4;
	localparam logic [3:0] ST_LEAD_ZERO   = 4'd5;
	localparam logic [3:0] ST_OVERFLOW    = 4'd6;
	localparam logic [3:0] ST_INCOMPLETE  = 4'd7;
	localparam logic [3:0] ST_TRAIL_COMMA = 4'd8;

	// input beat kind
	localparam logic KIND_CHAR = 1'b0;
	localparam logic KIND_END  = 1'b1;

	// characters
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;

	// result queue geometry
	localparam int RES_DEPTH = 4;
	localparam int RES_PTR_W = 2;
	localparam int RES_CNT_W = 3;

	typedef struct packed {
		logic        kind_out;
		logic [31:0] token_value;
		logic [3:0]  status;
		logic        last;
	} result_t;

	function automatic logic is_space(input logic [7:0] c);
		return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

endpackage

// ===== hw/rtl/json_uint_array_parser.sv =====
// ----------------------------------------------------------------------------
// json_uint_array_parser
// streaming parser for a strict json array of unsigned 32-bit decimals
// ----------------------------------------------------------------------------
// usage
//   slave side: one beat per text character (tuser = 0, tdata[7:0] = byte)
//   or an end-of-text beat (tuser = 1, tdata ignored)
//   master side: token beats (tuser = 0, tdata[31:0] = value) and one final
//   status beat per parse (tuser = 1, tlast = 1, tdata[35:32] = status)
//   a nonzero status tells the receiver to drop that parse's tokens
// pipeline and throughput
//   a beat is held in the input register and is parsed from there into a
//   four-entry result queue, from which its results are taken in order
//   one input beat per cycle sustained while two queue entries are free;
//   an end beat that closes a number yields two results, the token and
//   then the status
// reset
//   arst_n clears the parse state to "expecting opening bracket", empties
//   the input register and the result queue; an end beat also returns the
//   parser to that state for the next text
// stall
//   while the receiver holds tready low the queue fills; the input register
//   is parsed only when two queue entries are free, then tready drops
// ----------------------------------------------------------------------------
module json_uint_array_parser
	import juap_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] ch
	input  logic        s_axis_tuser,   // [0] kind
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,   // [31:0] token_value, [35:32] status, rest zero
	output logic        m_axis_tuser,   // [0] kind_out
	output logic        m_axis_tlast    // [0] last
);

	// input register
	logic       vld_s1;
	logic       kind_s1;
	logic [7:0] ch_s1;

	// parse state
	phase_t      phase_q,  phase_d;
	logic [31:0] acc_q,    acc_d;
	logic        zero_q,   zero_d;
	logic [3:0]  err_q,    err_d;

	// result queue
	result_t              res_mem_q [RES_DEPTH];
	logic [RES_PTR_W-1:0] wr_ptr_q;
	logic [RES_PTR_W-1:0] rd_ptr_q;
	logic [RES_CNT_W-1:0] cnt_q;

	logic                 proc;
	logic                 pop;
	logic [1:0]           n_res;
	result_t              res_a;
	result_t              res_b;
	logic [RES_PTR_W-1:0] wr_ptr_nx;

	// digit arithmetic: acc * 10 + d in 36 bits, overflow when the top bits are set
	logic [3:0]  dig;
	logic [35:0] prod;
	logic        ovf;

	assign dig  = ch_s1[3:0];
	assign prod = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1) + {32'b0, dig};
	assign ovf  = |prod[35:32];

	// parse the held beat only when two queue entries are free
	assign proc          = vld_s1 && (cnt_q <= RES_CNT_W'(RES_DEPTH - 2));
	assign s_axis_tready = !vld_s1 || proc;
	assign pop           = m_axis_tvalid && m_axis_tready;

	always_comb begin
		result_t tok;
		result_t sts;
		logic [3:0] st;

		tok             = '0;
		tok.kind_out    = KIND_CHAR;
		tok.token_value = acc_q;
		sts             = '0;
		sts.kind_out    = KIND_END;
		sts.last        = 1'b1;
		st              = ST_OK;

		phase_d = phase_q;
		acc_d   = acc_q;
		zero_d  = zero_q;
		err_d   = err_q;
		n_res   = 2'd0;
		res_a   = tok;
		res_b   = sts;

		if (kind_s1 == KIND_CHAR) begin
			// characters after a latched error are ignored
			if (err_q == ST_OK) begin
				unique case (phase_q)
					PH_OPEN: begin
						if (!is_space(ch_s1)) begin
							if (ch_s1 == CH_LBRACK) phase_d = PH_FIRST;
							else err_d = ST_NOT_ARRAY;
						end
					end
					PH_FIRST: begin
						if (!is_space(ch_s1)) begin
							if (ch_s1 == CH_RBRACK) begin
								phase_d = PH_EMPTY;
							end else if (is_digit(ch_s1)) begin
								acc_d   = {28'b0, dig};
								zero_d  = (ch_s1 == CH_ZERO);
								phase_d = PH_NUM;
							end else begin
								err_d = ST_NON_INT;
							end
						end
					end
					PH_ELEM: begin
						if (!is_space(ch_s1)) begin
							if (is_digit(ch_s1)) begin
								acc_d   = {28'b0, dig};
								zero_d  = (ch_s1 == CH_ZERO);
								phase_d = PH_NUM;
							end else if (ch_s1 == CH_RBRACK) begin
								err_d = ST_TRAIL_COMMA;
							end else begin
								err_d = ST_NON_INT;
							end
						end
					end
					PH_NUM: begin
						if (is_digit(ch_s1)) begin
							if (zero_q)   err_d = ST_LEAD_ZERO;
							else if (ovf) err_d = ST_OVERFLOW;
							else          acc_d = prod[31:0];
						end else begin
							// the terminating character emits the token
							n_res   = 2'd1;
							phase_d = PH_AFTER;
							if (!is_space(ch_s1)) begin
								if (ch_s1 == CH_RBRACK)     phase_d = PH_CLOSED;
								else if (ch_s1 == CH_COMMA) phase_d = PH_ELEM;
								else                        err_d   = ST_NOT_ARRAY;
							end
						end
					end
					PH_AFTER: begin
						if (!is_space(ch_s1)) begin
							if (ch_s1 == CH_RBRACK)     phase_d = PH_CLOSED;
							else if (ch_s1 == CH_COMMA) phase_d = PH_ELEM;
							else                        err_d   = ST_NOT_ARRAY;
						end
					end
					PH_CLOSED, PH_EMPTY: begin
						if (!is_space(ch_s1)) err_d = ST_TRAILING;
					end
					default: err_d = ST_NOT_ARRAY;
				endcase
			end
		end else begin
			// end of text: final status, then back to the reset state
			if (err_q != ST_OK) begin
				st = err_q;
			end else begin
				unique case (phase_q)
					PH_OPEN:   st = ST_NOT_ARRAY;
					PH_FIRST:  st = ST_NON_INT;
					PH_ELEM:   st = ST_TRAIL_COMMA;
					PH_NUM:    st = ST_INCOMPLETE;
					PH_AFTER:  st = ST_INCOMPLETE;
					PH_CLOSED: st = ST_OK;
					PH_EMPTY:  st = ST_EMPTY;
					default:   st = ST_NOT_ARRAY;
				endcase
			end
			sts.status = st;
			if (err_q == ST_OK && phase_q == PH_NUM) begin
				// open number: token first, then status
				n_res = 2'd2;
				res_a = tok;
				res_b = sts;
			end else begin
				n_res = 2'd1;
				res_a = sts;
			end
			phase_d = PH_OPEN;
			acc_d   = '0;
			zero_d  = 1'b0;
			err_d   = ST_OK;
		end
	end

	assign wr_ptr_nx = wr_ptr_q + RES_PTR_W'(1);

	// input register and parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			phase_q <= PH_OPEN;
			acc_q   <= '0;
			zero_q  <= 1'b0;
			err_q   <= ST_OK;
		end else begin
			if (s_axis_tready) vld_s1 <= s_axis_tvalid;
			if (proc) begin
				phase_q <= phase_d;
				acc_q   <= acc_d;
				zero_q  <= zero_d;
				err_q   <= err_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			kind_s1 <= s_axis_tuser;
			ch_s1   <= s_axis_tdata;
		end
	end

	// result queue control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (proc) wr_ptr_q <= wr_ptr_q + RES_PTR_W'(n_res);
			if (pop)  rd_ptr_q <= rd_ptr_q + RES_PTR_W'(1);
			cnt_q <= cnt_q + (proc ? RES_CNT_W'(n_res) : RES_CNT_W'(0))
			               - (pop ? RES_CNT_W'(1) : RES_CNT_W'(0));
		end
	end

	// result queue storage
	always_ff @(posedge clk) begin
		if (proc && n_res != 2'd0) res_mem_q[wr_ptr_q]  <= res_a;
		if (proc && n_res == 2'd2) res_mem_q[wr_ptr_nx] <= res_b;
	end

	// output beat
	assign m_axis_tvalid = (cnt_q != '0);
	assign m_axis_tdata  = {4'b0, res_mem_q[rd_ptr_q].status, res_mem_q[rd_ptr_q].token_value};
	assign m_axis_tuser  = res_mem_q[rd_ptr_q].kind_out;
	assign m_axis_tlast  = res_mem_q[rd_ptr_q].last;

endmodule
